### rtl/mhpq_pkg.sv
// Package for the min-heap priority queue: operation and status codes,
// the token control struct, the controller states and the value compare.
// Depends on nothing; used by mhpq_cell and min_heap_priority_queue_core.
package mhpq_pkg;

	localparam int VAL_W = 32;
	localparam int ENT_W = 11;

	typedef enum logic {
		OP_INS = 1'b0,
		OP_REM = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic vld;
		op_t  op;
	} ctl_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS,
		S_FA,
		S_FB,
		S_WAIT,
		S_RESP
	} state_t;

	function automatic logic val_less(input logic [VAL_W-1:0] a, input logic [VAL_W-1:0] b);
		return $signed(a) < $signed(b);
	endfunction

endpackage

### rtl/mhpq_cell.sv
// One heap level: left and right memories for the sibling pairs of level LVL,
// a read stage and a compare stage that passes the token to the next level.
// Depends on mhpq_pkg.
module mhpq_cell #(
	parameter int CAPACITY = 1024,
	parameter int LVL = 1,
	parameter int PW = 11,
	parameter int LW = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mhpq_pkg::ctl_t                in_ctl,
	input  logic [mhpq_pkg::VAL_W-1:0]    in_val,
	input  logic [PW-1:0]                 in_idx,
	input  logic [LW-1:0]                 in_lvl,
	output mhpq_pkg::ctl_t                out_ctl,
	output logic [mhpq_pkg::VAL_W-1:0]    out_val,
	output logic [PW-1:0]                 out_idx,
	output logic [LW-1:0]                 out_lvl,
	input  logic [PW-1:0]                 count,
	input  logic                          fetch_en,
	input  logic [PW-1:0]                 fetch_idx,
	output logic [mhpq_pkg::VAL_W-1:0]    fetch_val,
	input  logic                          wb_in_en,
	input  logic [PW-1:0]                 wb_in_idx,
	input  logic [mhpq_pkg::VAL_W-1:0]    wb_in_val,
	output logic                          wb_out_en,
	output logic [PW-1:0]                 wb_out_idx,
	output logic [mhpq_pkg::VAL_W-1:0]    wb_out_val,
	output logic                          fin
);
	import mhpq_pkg::*;

	localparam int FIRST = 2 ** LVL;
	localparam int NODES = (CAPACITY - FIRST + 1 < FIRST) ? (CAPACITY - FIRST + 1) : FIRST;
	localparam int RD = (NODES + 1) / 2;
	localparam int AW = (RD > 1) ? $clog2(RD) : 1;

	logic [VAL_W-1:0] mem_l [RD];
	logic [VAL_W-1:0] mem_r [RD];
	logic [VAL_W-1:0] rdl_q, rdr_q;

	logic [AW-1:0] ins_row, sft_row, fet_row, wbi_row, rd_row, w_row;
	logic          ins_side, fet_hit, rd_en;
	logic          wl_en, wr_en;
	logic [VAL_W-1:0] w_val;

	logic          vld_s1, fet_s1, side_s1;
	op_t           op_s1;
	logic [VAL_W-1:0] val_s1;
	logic [PW-1:0] idx_s1;
	logic [LW-1:0] lvl_s1;
	logic [AW-1:0] row_s1;

	logic [VAL_W-1:0] node, best_val, own_val, nxt_val, wbo_val;
	logic [PW-1:0]    kid_l, kid_r, kid, nxt_idx;
	logic             l_ok, r_ok, take, tside, own_we, own_side, nxt_vld, wbo_en, fin_d;

	generate
		if (LVL == 1) begin : g_first
			assign ins_row  = '0;
			assign ins_side = in_idx[PW-2];
			assign sft_row  = '0;
			assign fet_row  = '0;
			assign wbi_row  = '0;
		end else begin : g_deep
			logic [LVL-1:0] ins_pos;
			assign ins_pos  = in_idx[PW-2 -: LVL];
			assign ins_row  = ins_pos[AW:1];
			assign ins_side = ins_pos[0];
			assign sft_row  = in_idx[AW-1:0];
			assign fet_row  = fetch_idx[AW:1];
			assign wbi_row  = wb_in_idx[AW:1];
		end
	endgenerate

	assign fet_hit = fetch_en && (fetch_idx[PW-1:LVL] == (PW-LVL)'(1));
	assign rd_en   = in_ctl.vld || fet_hit;
	assign rd_row  = in_ctl.vld ? ((in_ctl.op == OP_INS) ? ins_row : sft_row) : fet_row;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdl_q <= mem_l[rd_row];
			rdr_q <= mem_r[rd_row];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			fet_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_ctl.vld;
			fet_s1 <= fet_hit && !in_ctl.vld;
		end
	end

	always_ff @(posedge clk) begin
		op_s1   <= in_ctl.op;
		val_s1  <= in_val;
		idx_s1  <= in_idx;
		lvl_s1  <= in_lvl;
		row_s1  <= in_ctl.vld ? rd_row : fet_row;
		side_s1 <= in_ctl.vld ? ins_side : fetch_idx[0];
	end

	always_comb begin
		node      = side_s1 ? rdr_q : rdl_q;
		fetch_val = fet_s1 ? node : '0;
		kid_l     = {idx_s1[PW-2:0], 1'b0};
		kid_r     = {idx_s1[PW-2:0], 1'b1};
		l_ok      = kid_l <= count;
		r_ok      = kid_r <= count;
		best_val  = val_s1;
		take      = 1'b0;
		tside     = 1'b0;
		kid       = kid_l;
		own_we    = 1'b0;
		own_side  = side_s1;
		own_val   = val_s1;
		nxt_vld   = 1'b0;
		nxt_val   = val_s1;
		nxt_idx   = idx_s1;
		wbo_en    = 1'b0;
		wbo_val   = val_s1;
		fin_d     = 1'b0;
		if (vld_s1) begin
			if (op_s1 == OP_INS) begin
				if (lvl_s1 == LW'(LVL)) begin
					own_we = 1'b1;
					fin_d  = 1'b1;
				end else begin
					nxt_vld = 1'b1;
					if (val_less(val_s1, node)) begin
						own_we  = 1'b1;
						nxt_val = node;
					end
				end
			end else begin
				if (l_ok && val_less(rdl_q, best_val)) begin
					best_val = rdl_q;
					take     = 1'b1;
					tside    = 1'b0;
				end
				if (r_ok && val_less(rdr_q, best_val)) begin
					best_val = rdr_q;
					take     = 1'b1;
					tside    = 1'b1;
				end
				wbo_en  = 1'b1;
				wbo_val = best_val;
				kid     = tside ? kid_r : kid_l;
				if (!take) begin
					fin_d = 1'b1;
				end else if (kid > (count >> 1)) begin
					own_we   = 1'b1;
					own_side = tside;
					fin_d    = 1'b1;
				end else begin
					nxt_vld = 1'b1;
					nxt_idx = kid;
				end
			end
		end
	end

	always_comb begin
		if (wb_in_en) begin
			w_row = wbi_row;
			w_val = wb_in_val;
			wl_en = !wb_in_idx[0];
			wr_en = wb_in_idx[0];
		end else begin
			w_row = row_s1;
			w_val = own_val;
			wl_en = own_we && !own_side;
			wr_en = own_we && own_side;
		end
	end

	always_ff @(posedge clk) begin
		if (wl_en) begin
			mem_l[w_row] <= w_val;
		end
		if (wr_en) begin
			mem_r[w_row] <= w_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ctl.vld <= 1'b0;
			out_ctl.op  <= OP_INS;
			wb_out_en   <= 1'b0;
			fin         <= 1'b0;
		end else begin
			out_ctl.vld <= nxt_vld;
			out_ctl.op  <= op_s1;
			wb_out_en   <= wbo_en;
			fin         <= fin_d;
		end
	end

	always_ff @(posedge clk) begin
		out_val    <= nxt_val;
		out_idx    <= nxt_idx;
		out_lvl    <= lvl_s1;
		wb_out_idx <= idx_s1;
		wb_out_val <= wbo_val;
	end

	a_tok_alone: assert property (@(posedge clk) disable iff (!arst_n)
		in_ctl.vld |-> !vld_s1 && !fet_s1)
		else $error("token entered a busy level");

	a_wb_no_clash: assert property (@(posedge clk) disable iff (!arst_n)
		wb_in_en |-> !vld_s1)
		else $error("write-back collided with a local write");

	a_hole_has_kid: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && op_s1 == OP_REM |-> ({1'b0, kid_l} <= {1'b0, count}))
		else $error("sift reached a level without a left child");

	a_fin_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		fin |=> !fin)
		else $error("level finished twice in a row");

endmodule

### rtl/min_heap_priority_queue_core.sv
// Top level of the min-heap priority queue: controller, root register and
// a chain of mhpq_cell levels, one per heap level below the root.
// Depends on mhpq_pkg and mhpq_cell.
//
//  channel   | handshake        | payload
//  ----------+------------------+-------------------------------------
//  command   | start / busy     | kind, value
//  result    | done (strobe)    | removed_value, status, entry_count
//
// An insert or a remove walks the token down the level chain below the
// root, one read and one compare per level. Empty and full cases and a
// remove from a single entry finish without the walk.
// Reset clears the entry count and the controller; the heap memories need
// no clearing. The result beat cannot be stalled.
module min_heap_priority_queue_core #(
	parameter int CAPACITY = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic                              kind,
	input  logic signed [mhpq_pkg::VAL_W-1:0] value,
	output logic                              done,
	output logic signed [mhpq_pkg::VAL_W-1:0] removed_value,
	output logic [1:0]                        status,
	output logic [mhpq_pkg::ENT_W-1:0]        entry_count
);
	import mhpq_pkg::*;

	localparam int LEVELS = $clog2(CAPACITY + 1);
	localparam int PW = LEVELS;
	localparam int LW = $clog2(LEVELS);

	state_t state_q, state_d;

	logic [PW-1:0]    count_q;
	logic [VAL_W-1:0] root_q, val_q, removed_q;
	status_t          status_q;

	ctl_t             tctl_q;
	logic [VAL_W-1:0] tval_q;
	logic [PW-1:0]    tidx_q;
	logic [LW-1:0]    tlvl_q;
	logic             fetch_en_q;
	logic [PW-1:0]    fetch_idx_q;

	ctl_t             tk_ctl [LEVELS];
	logic [VAL_W-1:0] tk_val [LEVELS];
	logic [PW-1:0]    tk_idx [LEVELS];
	logic [LW-1:0]    tk_lvl [LEVELS];

	logic             wb_en  [1:LEVELS];
	logic [PW-1:0]    wb_idx [1:LEVELS];
	logic [VAL_W-1:0] wb_val [1:LEVELS];

	logic [VAL_W-1:0] fv [1:LEVELS-1];
	logic [LEVELS-1:1] fin_v;

	logic             accept, is_ins, is_full, is_empty, fin_any;
	logic [VAL_W-1:0] fetched;
	logic [PW-1:0]    norm_idx;
	logic [LW-1:0]    norm_lvl;

	assign accept   = start && !busy;
	assign is_ins   = (op_t'(kind) == OP_INS);
	assign is_full  = (count_q == PW'(CAPACITY));
	assign is_empty = (count_q == '0);
	assign fin_any  = |fin_v;

	assign tk_ctl[0] = tctl_q;
	assign tk_val[0] = tval_q;
	assign tk_idx[0] = tidx_q;
	assign tk_lvl[0] = tlvl_q;

	assign wb_en[LEVELS]  = 1'b0;
	assign wb_idx[LEVELS] = '0;
	assign wb_val[LEVELS] = '0;

	generate
		for (genvar i = 1; i < LEVELS; i++) begin : g_lvl
			mhpq_cell #(
				.CAPACITY(CAPACITY),
				.LVL(i),
				.PW(PW),
				.LW(LW)
			) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.in_ctl    (tk_ctl[i-1]),
				.in_val    (tk_val[i-1]),
				.in_idx    (tk_idx[i-1]),
				.in_lvl    (tk_lvl[i-1]),
				.out_ctl   (tk_ctl[i]),
				.out_val   (tk_val[i]),
				.out_idx   (tk_idx[i]),
				.out_lvl   (tk_lvl[i]),
				.count     (count_q),
				.fetch_en  (fetch_en_q),
				.fetch_idx (fetch_idx_q),
				.fetch_val (fv[i]),
				.wb_in_en  (wb_en[i+1]),
				.wb_in_idx (wb_idx[i+1]),
				.wb_in_val (wb_val[i+1]),
				.wb_out_en (wb_en[i]),
				.wb_out_idx(wb_idx[i]),
				.wb_out_val(wb_val[i]),
				.fin       (fin_v[i])
			);
		end
	endgenerate

	always_comb begin
		fetched = '0;
		for (int i = 1; i < LEVELS; i++) begin
			fetched = fetched | fv[i];
		end
	end

	// The insert path is steered by the new entry's index with its leading
	// one moved to the top bit, so each level reads its own fixed bit slice.
	always_comb begin
		norm_lvl = '0;
		for (int i = 0; i < PW; i++) begin
			if (count_q[i]) begin
				norm_lvl = LW'(i);
			end
		end
		norm_idx = count_q << (LW'(PW - 1) - norm_lvl);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		busy    = 1'b1;
		done    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					if (is_ins) begin
						state_d = (is_full || is_empty) ? S_RESP : S_INS;
					end else begin
						state_d = (count_q <= PW'(1)) ? S_RESP : S_FA;
					end
				end
			end
			S_INS: state_d = S_WAIT;
			S_FA:  state_d = S_FB;
			S_FB:  state_d = (count_q == PW'(1)) ? S_RESP : S_WAIT;
			S_WAIT: begin
				if (fin_any) begin
					state_d = S_RESP;
				end
			end
			S_RESP: begin
				done    = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			tctl_q.vld <= 1'b0;
			tctl_q.op  <= OP_INS;
			fetch_en_q <= 1'b0;
		end else begin
			if (accept && is_ins && !is_full) begin
				count_q <= count_q + PW'(1);
			end else if (accept && !is_ins && !is_empty) begin
				count_q <= count_q - PW'(1);
			end
			fetch_en_q <= accept && !is_ins && (count_q > PW'(1));
			tctl_q.vld <= (state_q == S_INS) || (state_q == S_FB && count_q != PW'(1));
			if (state_q == S_INS) begin
				tctl_q.op <= OP_INS;
			end else if (state_q == S_FB) begin
				tctl_q.op <= OP_REM;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			val_q       <= value;
			fetch_idx_q <= count_q;
			removed_q   <= (!is_ins && !is_empty) ? root_q : '0;
			if (is_ins && is_full) begin
				status_q <= ST_FULL;
			end else if (!is_ins && is_empty) begin
				status_q <= ST_EMPTY;
			end else begin
				status_q <= ST_OK;
			end
			if (is_ins && is_empty) begin
				root_q <= value;
			end
		end
		if (state_q == S_INS) begin
			tidx_q    <= norm_idx;
			tlvl_q    <= norm_lvl;
			if (val_less(val_q, root_q)) begin
				root_q <= val_q;
				tval_q <= root_q;
			end else begin
				tval_q <= val_q;
			end
		end
		if (state_q == S_FB) begin
			tidx_q    <= PW'(1);
			tlvl_q    <= '0;
			tval_q    <= fetched;
			if (count_q == PW'(1)) begin
				root_q <= fetched;
			end
		end
		if (state_q == S_WAIT && wb_en[1]) begin
			root_q <= wb_val[1];
		end
	end

	assign removed_value = removed_q;
	assign status        = status_q;
	assign entry_count   = ENT_W'(count_q);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= PW'(CAPACITY))
		else $error("entry count above capacity");

	a_fin_single: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(fin_v))
		else $error("more than one level finished at once");

	a_fin_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		fin_any |-> state_q == S_WAIT)
		else $error("level finished outside the wait state");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		done && status_q == ST_FULL |-> count_q == PW'(CAPACITY))
		else $error("full beat with a count below capacity");

	a_empty_beat: assert property (@(posedge clk) disable iff (!arst_n)
		done && status_q == ST_EMPTY |-> count_q == '0 && removed_q == '0)
		else $error("empty beat with stale count or value");

endmodule
